// ----- rtl/core/tria3d_pkg.sv -----
package tria3d_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRACTION_BITS = 8;

  localparam int AREA_W    = 33;
  localparam int AREA_FRAC = 16;

  // edge components, cross-product terms, magnitudes, squares, root
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int HALF_W = MAG_W / 2;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  // root carries 2*FRACTION_BITS fraction bits; halve and rescale
  localparam int DROP = 2 * FRACTION_BITS + 1 - AREA_FRAC;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [AREA_W-1:0]            area_t;

endpackage

// ----- rtl/core/tria3d_if.sv -----
interface tria3d_in_if;
  import tria3d_pkg::*;

  logic   valid;
  logic   ready;
  coord_t a_x;
  coord_t a_y;
  coord_t a_z;
  coord_t b_x;
  coord_t b_y;
  coord_t b_z;
  coord_t c_x;
  coord_t c_y;
  coord_t c_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    output ready
  );
endinterface

interface tria3d_out_if;
  import tria3d_pkg::*;

  logic  valid;
  logic  ready;
  area_t area;

  modport source (
    output valid, area,
    input  ready
  );
  modport sink (
    input  valid, area,
    output ready
  );
endinterface

// ----- rtl/core/triangle_area_3d.sv -----
// Triangle area by cross product: takes one triangle (three signed Q7.8 vertices)
// per cycle and returns half the floored magnitude of (a-b) x (a-c) as an
// unsigned area with 16 fraction bits. Fully pipelined: one beat in and one beat
// out per cycle while res.ready is high, with 42 register stages in all. Six
// arithmetic stages (edges, products, cross terms, split squaring, square
// recombine, sum) feed a bit-per-stage square root of 35 stages, then an output
// register. A one-beat skid behind the pipeline lets the block keep accepting
// while a result waits; ready drops only once both the output register and the
// skid are full.
module triangle_area_3d (
  input  logic clk,
  input  logic rst,
  tria3d_in_if.sink    vtx,
  tria3d_out_if.source res
);
  import tria3d_pkg::*;

  logic adv;

  // stage 1: edge vectors
  logic                     v1;
  logic signed [DIFF_W-1:0] ux, uy, uz, vx, vy, vz;
  // stage 2: cross-product partial products
  logic                     v2;
  logic signed [PROD_W-1:0] prod [6];
  // stage 3: magnitudes of cross components
  logic                     v3;
  logic [MAG_W-1:0]         mag [3];
  // stage 4: split squaring
  logic                     v4;
  logic [MAG_W-1:0]         sq_hh [3];
  logic [MAG_W-1:0]         sq_hl [3];
  logic [MAG_W-1:0]         sq_ll [3];
  // stage 5: squares
  logic                     v5;
  logic [SQ_W-1:0]          sq [3];
  // stage 6: sum of squares
  logic                     v6;
  logic [SUM_W-1:0]         sum;
  // square root stages
  logic                     rt_v    [ROOT_W];
  logic [SUM_W-1:0]         rt_rad  [ROOT_W];
  logic [REM_W-1:0]         rt_rem  [ROOT_W];
  logic [ROOT_W-1:0]        rt_root [ROOT_W];
  // output side
  logic                     out_v;
  area_t                    out_area;
  logic                     skid_v;
  area_t                    skid_area;
  logic                     exit_v;
  area_t                    exit_area;
  logic                     take;

  assign adv       = !skid_v;
  assign vtx.ready = adv;

  logic signed [CROSS_W-1:0] cterm [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cterm[j] = CROSS_W'(prod[2*j]) - CROSS_W'(prod[2*j+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= vtx.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux <= DIFF_W'(vtx.a_x) - DIFF_W'(vtx.b_x);
      uy <= DIFF_W'(vtx.a_y) - DIFF_W'(vtx.b_y);
      uz <= DIFF_W'(vtx.a_z) - DIFF_W'(vtx.b_z);
      vx <= DIFF_W'(vtx.a_x) - DIFF_W'(vtx.c_x);
      vy <= DIFF_W'(vtx.a_y) - DIFF_W'(vtx.c_y);
      vz <= DIFF_W'(vtx.a_z) - DIFF_W'(vtx.c_z);

      prod[0] <= PROD_W'(uy) * PROD_W'(vz);
      prod[1] <= PROD_W'(uz) * PROD_W'(vy);
      prod[2] <= PROD_W'(uz) * PROD_W'(vx);
      prod[3] <= PROD_W'(ux) * PROD_W'(vz);
      prod[4] <= PROD_W'(ux) * PROD_W'(vy);
      prod[5] <= PROD_W'(uy) * PROD_W'(vx);

      for (int j = 0; j < 3; j++) begin
        mag[j] <= cterm[j][CROSS_W-1] ? MAG_W'(-cterm[j]) : MAG_W'(cterm[j]);

        sq_hh[j] <= MAG_W'(mag[j][MAG_W-1:HALF_W]) * MAG_W'(mag[j][MAG_W-1:HALF_W]);
        sq_hl[j] <= MAG_W'(mag[j][MAG_W-1:HALF_W]) * MAG_W'(mag[j][HALF_W-1:0]);
        sq_ll[j] <= MAG_W'(mag[j][HALF_W-1:0]) * MAG_W'(mag[j][HALF_W-1:0]);

        sq[j] <= (SQ_W'(sq_hh[j]) << MAG_W) + (SQ_W'(sq_hl[j]) << (HALF_W + 1))
               + SQ_W'(sq_ll[j]);
      end

      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    logic              pv;
    logic [SUM_W-1:0]  prad;
    logic [REM_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign pv    = v6;
      assign prad  = sum;
      assign prem  = '0;
      assign proot = '0;
    end else begin : g_next
      assign pv    = rt_v[k-1];
      assign prad  = rt_rad[k-1];
      assign prem  = rt_rem[k-1];
      assign proot = rt_root[k-1];
    end

    assign rem_sh = {prem[REM_W-3:0], prad[SUM_W-1:SUM_W-2]};
    assign trial  = REM_W'({proot, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[k] <= 1'b0;
      end else if (adv) begin
        rt_v[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_rad[k] <= prad << 2;
        if (rem_sh >= trial) begin
          rt_rem[k]  <= rem_sh - trial;
          rt_root[k] <= {proot[ROOT_W-2:0], 1'b1};
        end else begin
          rt_rem[k]  <= rem_sh;
          rt_root[k] <= {proot[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // halve and rescale to the area's fraction bits, saturating
  logic [ROOT_W+AREA_W-1:0] scaled;

  if (DROP >= 0) begin : g_down
    assign scaled = (ROOT_W + AREA_W)'(rt_root[ROOT_W-1] >> DROP);
  end else begin : g_up
    assign scaled = (ROOT_W + AREA_W)'(rt_root[ROOT_W-1]) << (-DROP);
  end

  assign exit_area = (|(scaled >> AREA_W)) ? '1 : AREA_W'(scaled);
  assign exit_v    = adv && rt_v[ROOT_W-1];
  assign take      = out_v && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        out_area <= skid_area;
        skid_v   <= 1'b0;
      end
    end else if (exit_v) begin
      if (!out_v || take) begin
        out_area <= exit_area;
        out_v    <= 1'b1;
      end else begin
        skid_area <= exit_area;
        skid_v    <= 1'b1;
      end
    end else if (take) begin
      out_v <= 1'b0;
    end
  end

  assign res.valid = out_v;
  assign res.area  = out_area;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid holds a beat while output register is empty");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> !vtx.ready)
    else $error("input accepted while skid is full");

  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    rt_v[ROOT_W-1] |-> rt_rem[ROOT_W-1] <= REM_W'({rt_root[ROOT_W-1], 1'b0}))
    else $error("square root remainder out of range");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_v && res.ready |=> !skid_v && out_v)
    else $error("skid beat not moved to output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_v && !skid_v)
    else $error("output not empty after reset");

endmodule
